>>> design/crs_pkg.sv
`default_nettype none
package crs_pkg;
    localparam int POINTS_MAX_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COUNT_W = 7;
    localparam int COORD_W = 32;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL = 1'b1;
endpackage
`default_nettype wire

>>> design/crs_if.sv
`default_nettype none
interface crs_in_if #(parameter int PW = 6, parameter int TW = 17);
    logic valid;
    logic ready;
    logic opcode;
    logic [PW-1:0] point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [TW-1:0] curve_param;
    modport source (output valid, opcode, point_index, point_x, point_y, point_z,
                    curve_param, input ready);
    modport sink (input valid, opcode, point_index, point_x, point_y, point_z,
                  curve_param, output ready);
endinterface

interface crs_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

>>> design/crs_coord.sv
`default_nettype none
// One coordinate: coefficients and Horner steps, one multiply per stage.
// Advances when en is high; all stages move together.
module crs_coord
    import crs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic signed [31:0] p0,
    input  wire logic signed [31:0] p1,
    input  wire logic signed [31:0] p2,
    input  wire logic signed [31:0] p3,
    input  wire logic [FRAC_BITS:0] u,
    output logic signed [31:0] pos
);
    localparam int AW = 38;
    localparam int UW = FRAC_BITS + 1;
    localparam int PW = AW + UW + 1;

    logic signed [AW-1:0] e3_reg, e2_reg, e1_reg, e0_reg;
    logic signed [AW-1:0] a1_reg, a2_reg, a3_reg;
    logic signed [AW-1:0] e1b_reg, e0b_reg, e0c_reg;
    logic [FRAC_BITS:0] u1_reg, u2_reg, u3_reg;
    logic signed [31:0] pos_reg;

    logic signed [AW-1:0] q0, q1, q2, q3;
    logic signed [PW-1:0] m1, m2, m3;
    logic signed [AW-1:0] h;

    assign q0 = AW'(p0);
    assign q1 = AW'(p1);
    assign q2 = AW'(p2);
    assign q3 = AW'(p3);
    // Arithmetic shift of the signed product is the floor division.
    assign m1 = PW'(e3_reg) * $signed({1'b0, u1_reg});
    assign m2 = PW'(a1_reg) * $signed({1'b0, u2_reg});
    assign m3 = PW'(a2_reg) * $signed({1'b0, u3_reg});
    assign h = a3_reg >>> 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e3_reg <= -q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2 + q3;
            e2_reg <= (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
            e1_reg <= q2 - q0;
            e0_reg <= q1 <<< 1;
            u1_reg <= u;
            a1_reg <= AW'(m1 >>> FRAC_BITS) + e2_reg;
            e1b_reg <= e1_reg;
            e0b_reg <= e0_reg;
            u2_reg <= u1_reg;
            a2_reg <= AW'(m2 >>> FRAC_BITS) + e1b_reg;
            e0c_reg <= e0b_reg;
            u3_reg <= u2_reg;
            a3_reg <= AW'(m3 >>> FRAC_BITS) + e0c_reg;
            if (h > AW'(64'sh7FFFFFFF))
                pos_reg <= 32'sh7FFFFFFF;
            else if (h < -AW'(64'sh80000000))
                pos_reg <= 32'sh80000000;
            else
                pos_reg <= h[31:0];
        end
    end
    assign pos = pos_reg;
endmodule
`default_nettype wire

>>> design/crs_front.sv
`default_nettype none
// Segment selection and the four replicated point tables.
module crs_front
    import crs_pkg::*;
#(
    parameter int POINTS_MAX = POINTS_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int PW = 6
)(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [COUNT_W-1:0] point_count,
    input  wire logic wr,
    input  wire logic [PW-1:0] wr_index,
    input  wire logic [3*COORD_W-1:0] wr_data,
    input  wire logic [FRAC_BITS:0] t_in,
    output logic [4*3*COORD_W-1:0] pts,
    output logic [FRAC_BITS:0] u_out
);
    localparam int IW = $clog2(POINTS_MAX);
    localparam int NW = IW + 1;
    localparam int TW = FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = (TW)'(1) << FRAC_BITS;

    logic [3*COORD_W-1:0] mem0 [POINTS_MAX];
    logic [3*COORD_W-1:0] mem1 [POINTS_MAX];
    logic [3*COORD_W-1:0] mem2 [POINTS_MAX];
    logic [3*COORD_W-1:0] mem3 [POINTS_MAX];

    logic [NW-1:0] n, segs;
    logic [FRAC_BITS:0] t;
    logic [TW+NW-1:0] prod;
    logic [NW+1:0] seg;
    logic [IW-1:0] i0, i1, i2, i3;
    logic [FRAC_BITS:0] u;
    logic [IW-1:0] s;

    always_comb
    begin
        if (point_count < COUNT_W'(4))
            n = NW'(4);
        else if (32'(point_count) > POINTS_MAX)
            n = NW'(POINTS_MAX);
        else
            n = NW'(point_count);
        segs = n - NW'(1);
        t = (t_in > ONE) ? ONE : t_in;
        prod = (TW + NW)'(t) * (TW + NW)'(segs);
        seg = (NW + 2)'(prod >> FRAC_BITS);
        u = {1'b0, prod[FRAC_BITS-1:0]};
        if (seg >= (NW + 2)'(segs))
        begin
            seg = (NW + 2)'(segs) - (NW + 2)'(1);
            u = ONE;
        end
        s = seg[IW-1:0];
        i1 = s;
        i0 = (seg == '0) ? s : s - IW'(1);
        i2 = s + IW'(1);
        i3 = (seg + (NW + 2)'(2) >= (NW + 2)'(n)) ? i2 : s + IW'(2);
    end

    always_ff @(posedge clk)
    begin
        if (wr && 32'(wr_index) < POINTS_MAX)
        begin
            mem0[wr_index[IW-1:0]] <= wr_data;
            mem1[wr_index[IW-1:0]] <= wr_data;
            mem2[wr_index[IW-1:0]] <= wr_data;
            mem3[wr_index[IW-1:0]] <= wr_data;
        end
        if (en)
        begin
            pts <= {mem3[i3], mem2[i2], mem1[i1], mem0[i0]};
            u_out <= u;
        end
    end
endmodule
`default_nettype wire

>>> design/catmull_rom_spline_eval.sv
`default_nettype none
// Uniform Catmull-Rom evaluator over a table of 3D Q16.16 control points.
// Write items (opcode 0) store a point and give no result; evaluate items
// (opcode 1) give one position. One item is accepted every cycle while the
// output does not stall; an evaluation reaches the output through a pipeline
// of a table read stage, a coefficient stage, three Horner multiply stages and
// a saturation stage. The whole pipeline holds while the output stalls.
// A point table entry must be written before an evaluation reads it.
module catmull_rom_spline_eval
    import crs_pkg::*;
#(
    parameter int POINTS_MAX = POINTS_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_we,
    input wire logic [COUNT_W-1:0] cfg_wdata,
    crs_in_if.sink in_ch,
    crs_out_if.source out_ch
);
    localparam int DEPTH = 6;

    logic [COUNT_W-1:0] count_reg;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic en, acc;
    logic [4*3*COORD_W-1:0] pts;
    logic [FRAC_BITS:0] u;

    assign en = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign acc = in_ch.valid && en;
    assign vld_next = en ? {vld_reg[DEPTH-2:0], acc && in_ch.opcode == OP_EVAL} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(4);
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;
            vld_reg <= vld_next;
        end
    end

    crs_front #(.POINTS_MAX(POINTS_MAX), .FRAC_BITS(FRAC_BITS),
                .PW($bits(in_ch.point_index))) u_front (
        .clk(clk), .en(en), .point_count(count_reg),
        .wr(acc && in_ch.opcode == OP_WRITE), .wr_index(in_ch.point_index),
        .wr_data({in_ch.point_z, in_ch.point_y, in_ch.point_x}),
        .t_in(in_ch.curve_param), .pts(pts), .u_out(u)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_coord
        logic signed [31:0] pos;
        crs_coord #(.FRAC_BITS(FRAC_BITS)) u_coord (
            .clk(clk), .en(en),
            .p0(pts[0*96 + c*32 +: 32]), .p1(pts[1*96 + c*32 +: 32]),
            .p2(pts[2*96 + c*32 +: 32]), .p3(pts[3*96 + c*32 +: 32]),
            .u(u), .pos(pos)
        );
    end

    assign out_ch.valid = vld_reg[DEPTH-1];
    assign out_ch.pos_x = g_coord[0].pos;
    assign out_ch.pos_y = g_coord[1].pos;
    assign out_ch.pos_z = g_coord[2].pos;
endmodule
`default_nettype wire
